/* hw/rtl/cbrf_pkg.sv */
// Shared types and constants for the cubic bisection root finder.
package cbrf_pkg;

    localparam int WORD_W = 32;

    localparam logic [1:0] REG_COEF_SQUARE   = 2'd0;
    localparam logic [1:0] REG_COEF_LINEAR   = 2'd1;
    localparam logic [1:0] REG_COEF_CONSTANT = 2'd2;
    localparam logic [1:0] REG_ITER_LIMIT    = 2'd3;

    localparam logic signed [31:0] COEF_SQUARE_RST   = -32'sd44291850;
    localparam logic signed [31:0] COEF_LINEAR_RST   = 32'sd0;
    localparam logic signed [31:0] COEF_CONSTANT_RST = 32'sd107186;
    localparam logic [6:0]         ITER_LIMIT_RST    = 7'd5;

    // Polynomial evaluation phases, one multiply per phase from EV_SQ to EV_TLIN
    typedef enum logic [2:0] {
        EV_IDLE,
        EV_SQ,
        EV_CUBE,
        EV_TSQ,
        EV_TLIN,
        EV_SUM
    } ev_state_t;

    // Solver sequencer states
    typedef enum logic [2:0] {
        SV_IDLE,
        SV_EVAL_LEFT,
        SV_MID,
        SV_EVAL_MID,
        SV_STEP,
        SV_OUT
    } sv_state_t;

    // Data handed from one bisection cell to the next
    typedef struct packed {
        logic signed [31:0] left_end;
        logic signed [31:0] right_end;
        logic signed [31:0] value_at_left;
        logic               frozen;
    } cell_bus_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

/* hw/rtl/cbrf_eval.sv */
// Sequential cubic evaluator: one 32x32 multiply per cycle.
module cbrf_eval #(
    parameter int FRAC_BITS = 28
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] x,
    input  logic signed [31:0] coef_square,
    input  logic signed [31:0] coef_linear,
    input  logic signed [31:0] coef_constant,
    output logic               done,
    output logic signed [31:0] fx
);

    cbrf_pkg::ev_state_t state_reg, state_next;
    logic signed [31:0] x_reg, x2_reg, x3_reg, t2_reg, t1_reg;
    logic signed [31:0] ma, mb, qm;
    logic signed [63:0] prod;
    logic signed [65:0] sum;

    assign prod = ma * mb;
    assign qm   = cbrf_pkg::sat32(66'(prod >>> FRAC_BITS));
    assign sum  = 66'(x3_reg) + 66'(t2_reg) + 66'(t1_reg) + 66'(coef_constant);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbrf_pkg::EV_IDLE: if (start) state_next = cbrf_pkg::EV_SQ;
            cbrf_pkg::EV_SQ:   state_next = cbrf_pkg::EV_CUBE;
            cbrf_pkg::EV_CUBE: state_next = cbrf_pkg::EV_TSQ;
            cbrf_pkg::EV_TSQ:  state_next = cbrf_pkg::EV_TLIN;
            cbrf_pkg::EV_TLIN: state_next = cbrf_pkg::EV_SUM;
            cbrf_pkg::EV_SUM:  state_next = cbrf_pkg::EV_IDLE;
            default:           state_next = cbrf_pkg::EV_IDLE;
        endcase
    end

    always_comb begin
        ma = x_reg;
        mb = x_reg;
        case (state_reg)
            cbrf_pkg::EV_CUBE: begin ma = x2_reg;      mb = x_reg;  end
            cbrf_pkg::EV_TSQ:  begin ma = coef_square; mb = x2_reg; end
            cbrf_pkg::EV_TLIN: begin ma = coef_linear; mb = x_reg;  end
            default:           begin ma = x_reg;       mb = x_reg;  end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbrf_pkg::EV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            cbrf_pkg::EV_IDLE: if (start) x_reg <= x;
            cbrf_pkg::EV_SQ:   x2_reg <= qm;
            cbrf_pkg::EV_CUBE: x3_reg <= qm;
            cbrf_pkg::EV_TSQ:  t2_reg <= qm;
            cbrf_pkg::EV_TLIN: t1_reg <= qm;
            default: ;
        endcase
    end

    assign done = (state_reg == cbrf_pkg::EV_SUM);
    assign fx   = cbrf_pkg::sat32(sum);

endmodule

/* hw/rtl/cbrf_cell.sv */
// One bisection cell: applies the sign test and registers the interval for the next cell.
module cbrf_cell (
    input  logic                 aclk,
    input  logic                 load,
    input  logic                 step,
    input  cbrf_pkg::cell_bus_t  init,
    input  cbrf_pkg::cell_bus_t  prev,
    input  logic signed [31:0]   mid,
    input  logic signed [31:0]   fm,
    output cbrf_pkg::cell_bus_t  cur
);

    cbrf_pkg::cell_bus_t cur_reg, cur_next;
    logic neg_prod, pos_prod;

    // sign of f(left)*f(mid) from the operand signs
    assign neg_prod = (prev.value_at_left != 0) && (fm != 0)
                      && (prev.value_at_left[31] != fm[31]);
    assign pos_prod = (prev.value_at_left != 0) && (fm != 0)
                      && (prev.value_at_left[31] == fm[31]);

    always_comb begin
        cur_next = prev;
        if (!prev.frozen) begin
            if (neg_prod) begin
                cur_next.right_end = mid;
            end else if (pos_prod) begin
                cur_next.left_end      = mid;
                cur_next.value_at_left = fm;
            end else begin
                cur_next.frozen = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= init;
        end else if (step) begin
            cur_reg <= cur_next;
        end
    end

    assign cur = cur_reg;

endmodule

/* hw/rtl/cubic_bisection_root_finder.sv */
// Top level of the cubic bisection root finder.
// Each input beat carries an interval [lower_bound, upper_bound] in signed
// Q4.28; the block evaluates f(x) = x^3 + c2*x^2 + c1*x + c0 at the left end,
// then performs iteration_limit halvings (0 acts as 1, above MAX_STEPS clamps)
// and returns one beat: the last midpoint, f there, and the exact_hit flag
// set when a zero sign product froze the interval. Items are solved one at a
// time. The polynomial is evaluated by a shared single-multiplier unit. The
// interval lives in a chain of two bisection cells that hand the interval
// back and forth, one cell per halving in ping-pong order.
// Coefficients may be written only while the block is idle.
module cubic_bisection_root_finder #(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 28
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lower_bound[31:0], upper_bound[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // root_estimate[31:0], residual[63:32]
    output logic        m_tuser,   // exact_hit
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    logic signed [31:0] coef_square_reg, coef_linear_reg, coef_constant_reg;
    logic [6:0]         iter_limit_reg;

    cbrf_pkg::sv_state_t state_reg, state_next;
    logic [CNT_W-1:0]   steps_reg, target_reg;
    logic               phase_reg;   // which cell holds the live interval
    logic signed [31:0] mid_reg, fm_reg;
    logic               ev_start, ev_done;
    logic signed [31:0] ev_x, ev_fx;
    logic signed [32:0] end_sum;
    logic [CNT_W-1:0]   lim_clamped;
    cbrf_pkg::cell_bus_t init_bus, c0_bus, c1_bus, live_bus;
    logic               load0, load1, step0, step1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_square_reg   <= cbrf_pkg::COEF_SQUARE_RST;
            coef_linear_reg   <= cbrf_pkg::COEF_LINEAR_RST;
            coef_constant_reg <= cbrf_pkg::COEF_CONSTANT_RST;
            iter_limit_reg    <= cbrf_pkg::ITER_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                cbrf_pkg::REG_COEF_SQUARE:   coef_square_reg   <= cfg_data;
                cbrf_pkg::REG_COEF_LINEAR:   coef_linear_reg   <= cfg_data;
                cbrf_pkg::REG_COEF_CONSTANT: coef_constant_reg <= cfg_data;
                cbrf_pkg::REG_ITER_LIMIT:    iter_limit_reg    <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (iter_limit_reg == 7'd0) begin
            lim_clamped = CNT_W'(1);
        end else if (32'(iter_limit_reg) > MAX_STEPS) begin
            lim_clamped = CNT_W'(MAX_STEPS);
        end else begin
            lim_clamped = CNT_W'(iter_limit_reg);
        end
    end

    assign live_bus = phase_reg ? c1_bus : c0_bus;
    assign end_sum  = 33'(live_bus.left_end) + 33'(live_bus.right_end);

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbrf_pkg::SV_IDLE:      if (s_tvalid) state_next = cbrf_pkg::SV_EVAL_LEFT;
            cbrf_pkg::SV_EVAL_LEFT: if (ev_done)  state_next = cbrf_pkg::SV_MID;
            cbrf_pkg::SV_MID:       state_next = cbrf_pkg::SV_EVAL_MID;
            cbrf_pkg::SV_EVAL_MID:  if (ev_done)  state_next = cbrf_pkg::SV_STEP;
            cbrf_pkg::SV_STEP: begin
                if (steps_reg + CNT_W'(1) == target_reg) state_next = cbrf_pkg::SV_OUT;
                else state_next = cbrf_pkg::SV_MID;
            end
            cbrf_pkg::SV_OUT:       if (m_tready) state_next = cbrf_pkg::SV_IDLE;
            default:                state_next = cbrf_pkg::SV_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = (state_reg == cbrf_pkg::SV_IDLE);
        m_tvalid = (state_reg == cbrf_pkg::SV_OUT);
        ev_start = 1'b0;
        ev_x     = mid_reg;
        load0    = 1'b0;
        load1    = 1'b0;
        step0    = 1'b0;
        step1    = 1'b0;
        case (state_reg)
            cbrf_pkg::SV_IDLE: begin
                ev_start = s_tvalid;
                ev_x     = s_tdata[31:0];
                load0    = s_tvalid;
            end
            cbrf_pkg::SV_MID: begin
                // evaluator captures the new midpoint as mid_reg takes it
                ev_start = 1'b1;
                ev_x     = end_sum[32:1];
            end
            cbrf_pkg::SV_STEP: begin
                step0 = phase_reg;
                step1 = !phase_reg;
            end
            default: ;
        endcase
    end

    assign init_bus.left_end      = s_tdata[31:0];
    assign init_bus.right_end     = s_tdata[63:32];
    assign init_bus.value_at_left = ev_fx;
    assign init_bus.frozen        = 1'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= cbrf_pkg::SV_IDLE;
            steps_reg  <= '0;
            target_reg <= '0;
            phase_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                cbrf_pkg::SV_IDLE: if (s_tvalid) begin
                    steps_reg  <= '0;
                    target_reg <= lim_clamped;
                    phase_reg  <= 1'b0;
                end
                cbrf_pkg::SV_STEP: begin
                    steps_reg <= steps_reg + CNT_W'(1);
                    phase_reg <= !phase_reg;
                end
                default: ;
            endcase
        end
        if (state_reg == cbrf_pkg::SV_MID) mid_reg <= end_sum[32:1];
        if (state_reg == cbrf_pkg::SV_EVAL_MID && ev_done) fm_reg <= ev_fx;
    end

    // left value captured into cell 0 when the first evaluation ends
    logic load_left;
    assign load_left = (state_reg == cbrf_pkg::SV_EVAL_LEFT) && ev_done;

    cbrf_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (ev_start),
        .x             (ev_x),
        .coef_square   (coef_square_reg),
        .coef_linear   (coef_linear_reg),
        .coef_constant (coef_constant_reg),
        .done          (ev_done),
        .fx            (ev_fx)
    );

    cbrf_pkg::cell_bus_t init_hold_reg, init0_bus;
    always_ff @(posedge aclk) begin
        if (state_reg == cbrf_pkg::SV_IDLE && s_tvalid) init_hold_reg <= init_bus;
    end
    always_comb begin
        init0_bus = init_hold_reg;
        init0_bus.value_at_left = ev_fx;
    end

    cbrf_cell u_cell0 (
        .aclk (aclk), .load (load_left), .step (step0), .init (init0_bus),
        .prev (c1_bus), .mid (mid_reg), .fm (fm_reg), .cur (c0_bus)
    );

    cbrf_cell u_cell1 (
        .aclk (aclk), .load (load1 & load0), .step (step1), .init (init0_bus),
        .prev (c0_bus), .mid (mid_reg), .fm (fm_reg), .cur (c1_bus)
    );

    assign m_tdata = {fm_reg, mid_reg};
    assign m_tuser = live_bus.frozen;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output open together");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cbrf_pkg::SV_STEP) |-> (steps_reg < target_reg))
        else $error("halving count overran");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
`endif

endmodule
